>>> rtl/core/fss_pkg.sv
// ---------------------------------------------------------------------------
// Feeder servo step sequencer package
// Shared constants, control word layout, microcode table and channel remap.
// ---------------------------------------------------------------------------
package fss_pkg;

    localparam int FEEDER_COUNT_DEF = 16;
    localparam int MIN_ANGLE_DEF    = 0;
    localparam int MAX_ANGLE_DEF    = 180;

    localparam int FEEDER_W  = 4;
    localparam int ANGLE_W   = 10;
    localparam int LEN_W     = 5;
    localparam int ANG_OUT_W = 8;
    localparam int TICKS_W   = 12;
    localparam int SETTLE_W  = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PC_W      = 4;
    localparam int COUNT_W   = 3;

    localparam logic [LEN_W-1:0] FEED_MIN_LEN = 5'd2;
    localparam logic [LEN_W-1:0] FEED_MAX_LEN = 5'd24;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_FEED = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GLOBAL_ENABLE = 3'd0,
        REG_FEEDER_MASK   = 3'd1,
        REG_FULL_ANGLE    = 3'd2,
        REG_HALF_ANGLE    = 3'd3,
        REG_RETRACT_ANGLE = 3'd4,
        REG_SETTLE_MS     = 3'd5,
        REG_MIN_TICKS     = 3'd6,
        REG_MAX_TICKS     = 3'd7
    } reg_idx_t;

    localparam logic                 RST_GLOBAL_ENABLE = 1'b1;
    localparam logic [15:0]          RST_FEEDER_MASK   = 16'hFFFF;
    localparam logic [ANG_OUT_W-1:0] RST_FULL_ANGLE    = 8'd90;
    localparam logic [ANG_OUT_W-1:0] RST_HALF_ANGLE    = 8'd45;
    localparam logic [ANG_OUT_W-1:0] RST_RETRACT_ANGLE = 8'd0;
    localparam logic [SETTLE_W-1:0]  RST_SETTLE_MS     = 16'd200;
    localparam logic [TICKS_W-1:0]   RST_MIN_TICKS     = 12'd0;
    localparam logic [TICKS_W-1:0]   RST_MAX_TICKS     = 12'd480;

    typedef enum logic [2:0] {
        SRC_REJECT,
        SRC_FULL,
        SRC_HALF,
        SRC_RETRACT,
        SRC_INPUT
    } src_t;

    typedef enum logic [1:0] {
        LAST_NEVER,
        LAST_ALWAYS,
        LAST_IF_END
    } last_sel_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_END,
        JMP_IF_REJECT,
        JMP_IF_SET,
        JMP_IF_NO_FULL,
        JMP_FULL_LOOP
    } jmp_t;

    typedef struct packed {
        logic            emit;
        src_t            src;
        last_sel_t       last_sel;
        jmp_t            jmp;
        logic [PC_W-1:0] target;
    } cw_t;

    typedef struct packed {
        logic                       ok;
        logic                       last;
        logic [FEEDER_W-1:0]        chan;
        logic [SETTLE_W-1:0]        settle;
        logic signed [ANGLE_W:0]    ang;
    } step_t;

    typedef struct packed {
        logic                 strobe;
        logic                 ok;
        logic [FEEDER_W-1:0]  chan;
        logic [TICKS_W-1:0]   ticks;
        logic [ANG_OUT_W-1:0] ang;
        logic [SETTLE_W-1:0]  settle;
        logic                 last;
    } result_t;

    localparam logic [PC_W-1:0] PC_CHK_REJECT = 4'd0;
    localparam logic [PC_W-1:0] PC_CHK_SET    = 4'd1;
    localparam logic [PC_W-1:0] PC_CHK_FULL   = 4'd2;
    localparam logic [PC_W-1:0] PC_FULL_A     = 4'd3;
    localparam logic [PC_W-1:0] PC_FULL_R     = 4'd4;
    localparam logic [PC_W-1:0] PC_FULL_B     = 4'd5;
    localparam logic [PC_W-1:0] PC_HALF_A     = 4'd6;
    localparam logic [PC_W-1:0] PC_HALF_R     = 4'd7;
    localparam logic [PC_W-1:0] PC_HALF_B     = 4'd8;
    localparam logic [PC_W-1:0] PC_REJECT     = 4'd9;
    localparam logic [PC_W-1:0] PC_SET        = 4'd10;

    function automatic cw_t ucode(input logic [PC_W-1:0] pc);
        cw_t w;
        w = '{emit: 1'b0, src: SRC_REJECT, last_sel: LAST_NEVER, jmp: JMP_END,
              target: PC_CHK_REJECT};
        unique case (pc)
            PC_CHK_REJECT: w = '{1'b0, SRC_REJECT, LAST_NEVER, JMP_IF_REJECT, PC_REJECT};
            PC_CHK_SET:    w = '{1'b0, SRC_REJECT, LAST_NEVER, JMP_IF_SET, PC_SET};
            PC_CHK_FULL:   w = '{1'b0, SRC_REJECT, LAST_NEVER, JMP_IF_NO_FULL, PC_HALF_A};
            PC_FULL_A:     w = '{1'b1, SRC_FULL, LAST_NEVER, JMP_NEXT, PC_CHK_REJECT};
            PC_FULL_R:     w = '{1'b1, SRC_RETRACT, LAST_NEVER, JMP_NEXT, PC_CHK_REJECT};
            PC_FULL_B:     w = '{1'b1, SRC_FULL, LAST_IF_END, JMP_FULL_LOOP, PC_FULL_A};
            PC_HALF_A:     w = '{1'b1, SRC_HALF, LAST_NEVER, JMP_NEXT, PC_CHK_REJECT};
            PC_HALF_R:     w = '{1'b1, SRC_RETRACT, LAST_NEVER, JMP_NEXT, PC_CHK_REJECT};
            PC_HALF_B:     w = '{1'b1, SRC_FULL, LAST_ALWAYS, JMP_END, PC_CHK_REJECT};
            PC_REJECT:     w = '{1'b1, SRC_REJECT, LAST_ALWAYS, JMP_END, PC_CHK_REJECT};
            PC_SET:        w = '{1'b1, SRC_INPUT, LAST_ALWAYS, JMP_END, PC_CHK_REJECT};
            default:       w = '{1'b0, SRC_REJECT, LAST_NEVER, JMP_END, PC_CHK_REJECT};
        endcase
        return w;
    endfunction

    function automatic logic [FEEDER_W-1:0] phys_chan(input logic [FEEDER_W-1:0] f);
        logic [FEEDER_W-1:0] c;
        c = f;
        unique case (f)
            4'd8:    c = 4'd15;
            4'd9:    c = 4'd14;
            4'd10:   c = 4'd13;
            4'd11:   c = 4'd8;
            4'd12:   c = 4'd9;
            4'd13:   c = 4'd10;
            4'd14:   c = 4'd11;
            4'd15:   c = 4'd12;
            default: c = f;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/fss_datapath.sv
// ---------------------------------------------------------------------------
// Feeder servo tick map pipeline
// Clamps each step angle and maps it to PWM ticks over four register stages.
// ---------------------------------------------------------------------------
module fss_datapath
    import fss_pkg::*;
#(
    parameter int MIN_ANGLE = MIN_ANGLE_DEF,
    parameter int MAX_ANGLE = MAX_ANGLE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_valid,
    input  step_t              step_in,
    input  logic [TICKS_W-1:0] min_ticks,
    input  logic [TICKS_W-1:0] max_ticks,
    output result_t            result
);

    localparam int SPAN        = MAX_ANGLE - MIN_ANGLE;
    localparam int RECIP_SHIFT = 24;
    localparam int MAG_W       = 20;
    localparam int PROD_W      = 22;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((34'd1 << RECIP_SHIFT) / SPAN);

    typedef struct packed {
        logic                 ok;
        logic                 last;
        logic [FEEDER_W-1:0]  chan;
        logic [SETTLE_W-1:0]  settle;
        logic [ANG_OUT_W-1:0] ang;
    } meta_t;

    logic                        v1_reg, v2_reg, v3_reg;
    step_t                       s1_reg;
    meta_t                       m2_reg, m3_reg;
    logic signed [PROD_W-1:0]    prod2_reg, prod2_next;
    logic [ANG_OUT_W-1:0]        clamp2;
    logic [MAG_W-1:0]            mag3_reg, mag3_next;
    logic [MAG_W-1:0]            qest3_reg, qest3_next;
    logic                        neg3_reg;
    logic [MAG_W+RECIP_W-1:0]    recip_prod;
    logic [PROD_W-1:0]           abs_prod;
    logic [MAG_W-1:0]            qspan, rem, q;
    logic signed [TICKS_W+1:0]   qs, t;
    logic signed [TICKS_W:0]     diff;
    logic [ANG_OUT_W-1:0]        coff;
    result_t                     res_reg, res_next;

    always_comb
    begin
        if (s1_reg.ang < $signed((ANGLE_W+1)'(MIN_ANGLE)))
        begin
            clamp2 = ANG_OUT_W'(MIN_ANGLE);
        end
        else if (s1_reg.ang > $signed((ANGLE_W+1)'(MAX_ANGLE)))
        begin
            clamp2 = ANG_OUT_W'(MAX_ANGLE);
        end
        else
        begin
            clamp2 = s1_reg.ang[ANG_OUT_W-1:0];
        end
        coff       = clamp2 - ANG_OUT_W'(MIN_ANGLE);
        diff       = $signed({1'b0, max_ticks}) - $signed({1'b0, min_ticks});
        prod2_next = PROD_W'($signed({1'b0, coff}) * diff);
    end

    always_comb
    begin
        abs_prod   = prod2_reg[PROD_W-1] ? PROD_W'(-prod2_reg) : PROD_W'(prod2_reg);
        mag3_next  = abs_prod[MAG_W-1:0];
        recip_prod = (MAG_W+RECIP_W)'(mag3_next) * (MAG_W+RECIP_W)'(RECIP);
        qest3_next = recip_prod[RECIP_SHIFT +: MAG_W];
    end

    always_comb
    begin
        qspan = MAG_W'(qest3_reg * MAG_W'(SPAN));
        rem   = mag3_reg - qspan;
        q     = (rem >= MAG_W'(SPAN)) ? qest3_reg + MAG_W'(1) : qest3_reg;
        qs    = $signed({2'b00, q[TICKS_W-1:0]});
        t     = $signed({2'b00, min_ticks}) + (neg3_reg ? -qs : qs);

        res_next.strobe = v3_reg;
        res_next.ok     = m3_reg.ok;
        res_next.chan   = m3_reg.chan;
        res_next.ticks  = m3_reg.ok ? t[TICKS_W-1:0] : '0;
        res_next.ang    = m3_reg.ang;
        res_next.settle = m3_reg.settle;
        res_next.last   = m3_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            v1_reg  <= step_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg      <= step_in;
        prod2_reg   <= prod2_next;
        m2_reg.ok     <= s1_reg.ok;
        m2_reg.last   <= s1_reg.last;
        m2_reg.chan   <= s1_reg.chan;
        m2_reg.settle <= s1_reg.settle;
        m2_reg.ang    <= s1_reg.ok ? clamp2 : '0;
        m3_reg      <= m2_reg;
        mag3_reg    <= mag3_next;
        qest3_reg   <= qest3_next;
        neg3_reg    <= prod2_reg[PROD_W-1];
    end

    assign result = res_reg;

endmodule

>>> rtl/core/feeder_servo_step_sequencer_top.sv
// ---------------------------------------------------------------------------
// Feeder servo step sequencer
// Microcoded sequencer that turns set-angle and feed commands into servo
// steps, each mapped to PWM ticks by a pipelined datapath.
//
// Channel  Handshake          Payload
// input    start / busy       cmd, feeder, angle, feed_length
// config   cfg_wr             cfg_addr, cfg_data
// result   strobe (1 cycle)   ok, channel, ticks, out_angle, settle_ms, last
//
// busy is high from the cycle after start is taken until the last step is
// issued. Once its check states are done, the microcode issues one step per
// cycle; each step passes through the datapath registers before its result
// appears.
// Reset leaves the registers at their documented values and the block idle.
// The receiver cannot stall: strobe marks a beat for exactly one cycle.
// ---------------------------------------------------------------------------
module feeder_servo_step_sequencer_top
    import fss_pkg::*;
#(
    parameter int FEEDER_COUNT = FEEDER_COUNT_DEF,
    parameter int MIN_ANGLE    = MIN_ANGLE_DEF,
    parameter int MAX_ANGLE    = MAX_ANGLE_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       cmd,
    input  logic [FEEDER_W-1:0]        feeder,
    input  logic signed [ANGLE_W-1:0]  angle,
    input  logic [LEN_W-1:0]           feed_length,
    input  logic                       cfg_wr,
    input  logic [CFG_IDX_W-1:0]       cfg_addr,
    input  logic [CFG_W-1:0]           cfg_data,
    output logic                       strobe,
    output logic                       ok,
    output logic [FEEDER_W-1:0]        channel,
    output logic [TICKS_W-1:0]         ticks,
    output logic [ANG_OUT_W-1:0]       out_angle,
    output logic [SETTLE_W-1:0]        settle_ms,
    output logic                       last
);

    logic                       global_enable_reg;
    logic [15:0]                feeder_mask_reg;
    logic [ANG_OUT_W-1:0]       full_angle_reg;
    logic [ANG_OUT_W-1:0]       half_angle_reg;
    logic [ANG_OUT_W-1:0]       retract_angle_reg;
    logic [SETTLE_W-1:0]        settle_reg;
    logic [TICKS_W-1:0]         min_ticks_reg;
    logic [TICKS_W-1:0]         max_ticks_reg;

    logic                       run_reg, run_next;
    logic [PC_W-1:0]            pc_reg, pc_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic                       half_reg, half_next;
    logic                       reject_reg, reject_next;
    logic                       cmd_reg, cmd_next;
    logic [FEEDER_W-1:0]        feeder_reg, feeder_next;
    logic signed [ANGLE_W-1:0]  angle_reg, angle_next;

    logic                       accept;
    logic                       feeder_ok;
    logic                       len_ok;
    logic                       end_of_feed;
    cw_t                        cw;
    logic                       step_valid;
    step_t                      step;
    result_t                    result;

    assign accept = start && !run_reg;
    assign busy   = run_reg;
    assign cw     = ucode(pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_enable_reg <= RST_GLOBAL_ENABLE;
            feeder_mask_reg   <= RST_FEEDER_MASK;
            full_angle_reg    <= RST_FULL_ANGLE;
            half_angle_reg    <= RST_HALF_ANGLE;
            retract_angle_reg <= RST_RETRACT_ANGLE;
            settle_reg        <= RST_SETTLE_MS;
            min_ticks_reg     <= RST_MIN_TICKS;
            max_ticks_reg     <= RST_MAX_TICKS;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_GLOBAL_ENABLE: global_enable_reg <= cfg_data[0];
                REG_FEEDER_MASK:   feeder_mask_reg   <= cfg_data;
                REG_FULL_ANGLE:    full_angle_reg    <= cfg_data[ANG_OUT_W-1:0];
                REG_HALF_ANGLE:    half_angle_reg    <= cfg_data[ANG_OUT_W-1:0];
                REG_RETRACT_ANGLE: retract_angle_reg <= cfg_data[ANG_OUT_W-1:0];
                REG_SETTLE_MS:     settle_reg        <= cfg_data[SETTLE_W-1:0];
                REG_MIN_TICKS:     min_ticks_reg     <= cfg_data[TICKS_W-1:0];
                REG_MAX_TICKS:     max_ticks_reg     <= cfg_data[TICKS_W-1:0];
                default:           global_enable_reg <= global_enable_reg;
            endcase
        end
    end

    always_comb
    begin
        feeder_ok = ({1'b0, feeder} < (FEEDER_W+1)'(FEEDER_COUNT)) && feeder_mask_reg[feeder];
        len_ok    = !feed_length[0] && (feed_length >= FEED_MIN_LEN)
                    && (feed_length <= FEED_MAX_LEN);
        end_of_feed = (count_reg == COUNT_W'(1)) && !half_reg;

        run_next    = run_reg;
        pc_next     = pc_reg;
        count_next  = count_reg;
        half_next   = half_reg;
        reject_next = reject_reg;
        cmd_next    = cmd_reg;
        feeder_next = feeder_reg;
        angle_next  = angle_reg;

        if (accept)
        begin
            run_next    = 1'b1;
            pc_next     = PC_CHK_REJECT;
            count_next  = feed_length[LEN_W-1:2];
            half_next   = feed_length[1];
            reject_next = !global_enable_reg || !feeder_ok || ((cmd == CMD_FEED) && !len_ok);
            cmd_next    = cmd;
            feeder_next = feeder;
            angle_next  = angle;
        end
        else if (run_reg)
        begin
            unique case (cw.jmp)
                JMP_NEXT:       pc_next = pc_reg + PC_W'(1);
                JMP_END:        run_next = 1'b0;
                JMP_IF_REJECT:  pc_next = reject_reg ? cw.target : pc_reg + PC_W'(1);
                JMP_IF_SET:     pc_next = (cmd_reg == CMD_SET) ? cw.target : pc_reg + PC_W'(1);
                JMP_IF_NO_FULL: pc_next = (count_reg == '0) ? cw.target : pc_reg + PC_W'(1);
                JMP_FULL_LOOP:
                begin
                    count_next = count_reg - COUNT_W'(1);
                    priority if (count_reg != COUNT_W'(1))
                    begin
                        pc_next = cw.target;
                    end
                    else if (half_reg)
                    begin
                        pc_next = pc_reg + PC_W'(1);
                    end
                    else
                    begin
                        run_next = 1'b0;
                    end
                end
                default:        run_next = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        step_valid  = run_reg && cw.emit;
        step.ok     = 1'b1;
        step.chan   = phys_chan(feeder_reg);
        step.settle = settle_reg;
        step.ang    = '0;
        unique case (cw.src)
            SRC_REJECT:
            begin
                step.ok     = 1'b0;
                step.chan   = '0;
                step.settle = '0;
            end
            SRC_FULL:    step.ang = $signed({3'b000, full_angle_reg});
            SRC_HALF:    step.ang = $signed({3'b000, half_angle_reg});
            SRC_RETRACT: step.ang = $signed({3'b000, retract_angle_reg});
            SRC_INPUT:
            begin
                step.ang    = $signed({angle_reg[ANGLE_W-1], angle_reg});
                step.settle = '0;
            end
            default:     step.ok = 1'b0;
        endcase
        unique case (cw.last_sel)
            LAST_NEVER:  step.last = 1'b0;
            LAST_ALWAYS: step.last = 1'b1;
            LAST_IF_END: step.last = end_of_feed;
            default:     step.last = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            pc_reg  <= PC_CHK_REJECT;
        end
        else
        begin
            run_reg <= run_next;
            pc_reg  <= pc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        half_reg   <= half_next;
        reject_reg <= reject_next;
        cmd_reg    <= cmd_next;
        feeder_reg <= feeder_next;
        angle_reg  <= angle_next;
    end

    fss_datapath #(
        .MIN_ANGLE (MIN_ANGLE),
        .MAX_ANGLE (MAX_ANGLE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step_valid),
        .step_in    (step),
        .min_ticks  (min_ticks_reg),
        .max_ticks  (max_ticks_reg),
        .result     (result)
    );

    assign strobe    = result.strobe;
    assign ok        = result.ok;
    assign channel   = result.chan;
    assign ticks     = result.ticks;
    assign out_angle = result.ang;
    assign settle_ms = result.settle;
    assign last      = result.last;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a command beat");

    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(step_valid && step.last))
        else $error("sequence ended without a final step");

    a_loop_count: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg && cw.jmp == JMP_FULL_LOOP |-> count_reg != '0)
        else $error("advance loop entered with no triples left");

    a_reject_beat: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !ok |-> last && ticks == '0 && settle_ms == '0 && channel == '0)
        else $error("rejection beat carries payload");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Feeder servo step sequencer testbench
// Drives set-angle and feed commands through the start/busy port, and
// programs the eight registers between phases while the block is idle.
// A predictor works out the servo steps of each accepted command and queues
// them. Every result beat is checked field by field against the oldest step
// in that queue. The run starts with a table of directed rows, some of them
// carrying a hand-written expected step, and then goes through random
// phases, each one with its own register setting.
// ---------------------------------------------------------------------------
module testbench;

    import fss_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 7;

    typedef struct packed {
        logic                 ok;
        logic [FEEDER_W-1:0]  chan;
        logic [TICKS_W-1:0]   ticks;
        logic [ANG_OUT_W-1:0] ang;
        logic [SETTLE_W-1:0]  settle;
        logic                 last;
    } servo_step_t;

    typedef struct {
        logic                 en;
        logic [15:0]          mask;
        logic [ANG_OUT_W-1:0] full;
        logic [ANG_OUT_W-1:0] half;
        logic [ANG_OUT_W-1:0] retract;
        logic [SETTLE_W-1:0]  settle;
        logic [TICKS_W-1:0]   min_t;
        logic [TICKS_W-1:0]   max_t;
    } servo_regs_t;

    typedef enum logic {
        ROW_BEAT,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic                      cmd;
        logic [FEEDER_W-1:0]       feeder;
        logic signed [ANGLE_W-1:0] angle;
        logic [LEN_W-1:0]          len;
        reg_idx_t                  idx;
        logic [CFG_W-1:0]          value;
        logic                      fixed;
        servo_step_t               want;
    } row_t;

    localparam servo_step_t REJECTED = '{1'b0, 4'd0, 12'd0, 8'd0, 16'd0, 1'b1};
    localparam servo_step_t NO_STEP  = '0;

    localparam logic [FEEDER_W-1:0] CHANNEL_MAP [16] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd15, 4'd14, 4'd13, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12
    };

    localparam row_t DIRECTED [34] = '{
        '{ROW_BEAT, CMD_SET, 4'd0, 10'sd0, 5'd0, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          '{1'b1, 4'd0, 12'd0, 8'd0, 16'd0, 1'b1}},
        '{ROW_BEAT, CMD_SET, 4'd8, 10'sd180, 5'd0, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          '{1'b1, 4'd15, 12'd480, 8'd180, 16'd0, 1'b1}},
        '{ROW_BEAT, CMD_SET, 4'd15, -10'sd512, 5'd0, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          '{1'b1, 4'd12, 12'd0, 8'd0, 16'd0, 1'b1}},
        '{ROW_BEAT, CMD_SET, 4'd11, 10'sd511, 5'd0, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          '{1'b1, 4'd8, 12'd480, 8'd180, 16'd0, 1'b1}},
        '{ROW_BEAT, CMD_SET, 4'd9, 10'sd90, 5'd0, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          '{1'b1, 4'd14, 12'd240, 8'd90, 16'd0, 1'b1}},
        '{ROW_BEAT, CMD_SET, 4'd5, 10'sd45, 5'd31, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          '{1'b1, 4'd5, 12'd120, 8'd45, 16'd0, 1'b1}},
        '{ROW_BEAT, CMD_SET, 4'd3, -10'sd1, 5'd0, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          '{1'b1, 4'd3, 12'd0, 8'd0, 16'd0, 1'b1}},
        '{ROW_BEAT, CMD_FEED, 4'd2, 10'sd0, 5'd0, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          REJECTED},
        '{ROW_BEAT, CMD_FEED, 4'd2, 10'sd0, 5'd1, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          REJECTED},
        '{ROW_BEAT, CMD_FEED, 4'd2, 10'sd0, 5'd3, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          REJECTED},
        '{ROW_BEAT, CMD_FEED, 4'd4, 10'sd0, 5'd25, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          REJECTED},
        '{ROW_BEAT, CMD_FEED, 4'd4, 10'sd0, 5'd26, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          REJECTED},
        '{ROW_BEAT, CMD_FEED, 4'd4, 10'sd0, 5'd31, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          REJECTED},
        '{ROW_BEAT, CMD_FEED, 4'd1, 10'sd0, 5'd2, REG_GLOBAL_ENABLE, 16'd0, 1'b0,
          NO_STEP},
        '{ROW_BEAT, CMD_FEED, 4'd10, -10'sd512, 5'd4, REG_GLOBAL_ENABLE, 16'd0, 1'b0,
          NO_STEP},
        '{ROW_BEAT, CMD_FEED, 4'd12, 10'sd0, 5'd6, REG_GLOBAL_ENABLE, 16'd0, 1'b0,
          NO_STEP},
        '{ROW_BEAT, CMD_FEED, 4'd13, 10'sd511, 5'd24, REG_GLOBAL_ENABLE, 16'd0, 1'b0,
          NO_STEP},
        '{ROW_BEAT, CMD_FEED, 4'd14, 10'sd0, 5'd22, REG_GLOBAL_ENABLE, 16'd0, 1'b0,
          NO_STEP},
        '{ROW_REG, CMD_SET, 4'd0, 10'sd0, 5'd0, REG_FEEDER_MASK, 16'h7FFE, 1'b0,
          NO_STEP},
        '{ROW_BEAT, CMD_FEED, 4'd15, 10'sd0, 5'd4, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          REJECTED},
        '{ROW_BEAT, CMD_SET, 4'd0, 10'sd10, 5'd0, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          REJECTED},
        '{ROW_BEAT, CMD_SET, 4'd7, 10'sd100, 5'd0, REG_GLOBAL_ENABLE, 16'd0, 1'b0,
          NO_STEP},
        '{ROW_REG, CMD_SET, 4'd0, 10'sd0, 5'd0, REG_GLOBAL_ENABLE, 16'd0, 1'b0,
          NO_STEP},
        '{ROW_BEAT, CMD_FEED, 4'd4, 10'sd0, 5'd8, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          REJECTED},
        '{ROW_REG, CMD_SET, 4'd0, 10'sd0, 5'd0, REG_GLOBAL_ENABLE, 16'd1, 1'b0,
          NO_STEP},
        '{ROW_REG, CMD_SET, 4'd0, 10'sd0, 5'd0, REG_FEEDER_MASK, 16'hFFFF, 1'b0,
          NO_STEP},
        '{ROW_REG, CMD_SET, 4'd0, 10'sd0, 5'd0, REG_MIN_TICKS, 16'd4095, 1'b0,
          NO_STEP},
        '{ROW_REG, CMD_SET, 4'd0, 10'sd0, 5'd0, REG_MAX_TICKS, 16'd0, 1'b0,
          NO_STEP},
        '{ROW_REG, CMD_SET, 4'd0, 10'sd0, 5'd0, REG_FULL_ANGLE, 16'd180, 1'b0,
          NO_STEP},
        '{ROW_REG, CMD_SET, 4'd0, 10'sd0, 5'd0, REG_HALF_ANGLE, 16'd255, 1'b0,
          NO_STEP},
        '{ROW_REG, CMD_SET, 4'd0, 10'sd0, 5'd0, REG_SETTLE_MS, 16'd65535, 1'b0,
          NO_STEP},
        '{ROW_BEAT, CMD_FEED, 4'd6, 10'sd0, 5'd6, REG_GLOBAL_ENABLE, 16'd0, 1'b0,
          NO_STEP},
        '{ROW_BEAT, CMD_SET, 4'd1, 10'sd511, 5'd0, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          '{1'b1, 4'd1, 12'd0, 8'd180, 16'd0, 1'b1}},
        '{ROW_BEAT, CMD_SET, 4'd2, -10'sd512, 5'd0, REG_GLOBAL_ENABLE, 16'd0, 1'b1,
          '{1'b1, 4'd2, 12'd4095, 8'd0, 16'd0, 1'b1}}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      cmd;
    logic [FEEDER_W-1:0]       feeder;
    logic signed [ANGLE_W-1:0] angle;
    logic [LEN_W-1:0]          feed_length;
    logic                      cfg_wr;
    logic [CFG_IDX_W-1:0]      cfg_addr;
    logic [CFG_W-1:0]          cfg_data;
    logic                      strobe;
    logic                      ok;
    logic [FEEDER_W-1:0]       channel;
    logic [TICKS_W-1:0]        ticks;
    logic [ANG_OUT_W-1:0]      out_angle;
    logic [SETTLE_W-1:0]       settle_ms;
    logic                      last;

    servo_step_t pending_steps [$];
    servo_regs_t regs;
    int          errors       = 0;
    int          quiet_cycles = 0;
    int          burst_left   = 0;
    logic        gaps_on      = 1'b1;

    feeder_servo_step_sequencer_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .feeder      (feeder),
        .angle       (angle),
        .feed_length (feed_length),
        .cfg_wr      (cfg_wr),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .strobe      (strobe),
        .ok          (ok),
        .channel     (channel),
        .ticks       (ticks),
        .out_angle   (out_angle),
        .settle_ms   (settle_ms),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [TICKS_W-1:0] tick_map(input int c);
        int span;
        int t;
        span = MAX_ANGLE_DEF - MIN_ANGLE_DEF;
        t = (c - MIN_ANGLE_DEF) * (int'(regs.max_t) - int'(regs.min_t)) / span
            + int'(regs.min_t);
        return t[TICKS_W-1:0];
    endfunction

    function automatic servo_step_t servo_step(input logic [FEEDER_W-1:0] f, input int a,
                                               input logic [SETTLE_W-1:0] settle,
                                               input logic fin);
        int c;
        c = a;
        if (c < MIN_ANGLE_DEF)
            c = MIN_ANGLE_DEF;
        if (c > MAX_ANGLE_DEF)
            c = MAX_ANGLE_DEF;
        return '{1'b1, CHANNEL_MAP[f], tick_map(c), c[ANG_OUT_W-1:0], settle, fin};
    endfunction

    function automatic void predict_command(input logic c, input logic [FEEDER_W-1:0] f,
                                            input logic signed [ANGLE_W-1:0] a,
                                            input logic [LEN_W-1:0] len);
        int steps;
        int k;
        int target;
        if (!regs.en || !regs.mask[f])
        begin
            pending_steps.push_back(REJECTED);
            return;
        end
        if (c == CMD_SET)
        begin
            pending_steps.push_back(servo_step(f, int'(a), '0, 1'b1));
            return;
        end
        if (len < FEED_MIN_LEN || len > FEED_MAX_LEN || len[0])
        begin
            pending_steps.push_back(REJECTED);
            return;
        end
        // the half triple, if any, is the final one
        steps = 3 * (int'(len) / 4 + int'(len[1]));
        for (k = 0; k < steps; k++)
        begin
            if (k % 3 == 1)
                target = regs.retract;
            else if (k % 3 == 0 && len[1] && k == steps - 3)
                target = regs.half;
            else
                target = regs.full;
            pending_steps.push_back(servo_step(f, target, regs.settle, k == steps - 1));
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic int unsigned pick(input int unsigned hi);
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r < 2)
            return 0;
        if (r < 4)
            return hi;
        return $urandom_range(0, hi);
    endfunction

    task automatic cfg_write(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_wr   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_wr <= 1'b0;
        case (idx)
            REG_GLOBAL_ENABLE: regs.en      = value[0];
            REG_FEEDER_MASK:   regs.mask    = value;
            REG_FULL_ANGLE:    regs.full    = value[ANG_OUT_W-1:0];
            REG_HALF_ANGLE:    regs.half    = value[ANG_OUT_W-1:0];
            REG_RETRACT_ANGLE: regs.retract = value[ANG_OUT_W-1:0];
            REG_SETTLE_MS:     regs.settle  = value;
            REG_MIN_TICKS:     regs.min_t   = value[TICKS_W-1:0];
            REG_MAX_TICKS:     regs.max_t   = value[TICKS_W-1:0];
            default:           ;
        endcase
        @(posedge clk);
    endtask

    task automatic await_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_steps.size() != 0 || busy);
    endtask

    task automatic send_command(input logic c, input logic [FEEDER_W-1:0] f,
                                input logic signed [ANGLE_W-1:0] a,
                                input logic [LEN_W-1:0] len,
                                input logic fixed, input servo_step_t want);
        start       <= 1'b1;
        cmd         <= c;
        feeder      <= f;
        angle       <= a;
        feed_length <= len;
        do
            @(posedge clk);
        while (busy);
        if (fixed)
            pending_steps.push_back(want);
        else
            predict_command(c, f, a, len);
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 9);
            gap = $urandom_range(1, 25);
            if (gaps_on)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic randomise_regs(input logic enable);
        logic [15:0] mask;
        case ($urandom_range(0, 2))
            0:       mask = 16'hFFFF;
            1:       mask = 16'($urandom | $urandom);
            default: mask = 16'($urandom);
        endcase
        cfg_write(REG_GLOBAL_ENABLE, {15'd0, enable});
        cfg_write(REG_FEEDER_MASK, mask);
        cfg_write(REG_FULL_ANGLE, 16'(pick(255)));
        cfg_write(REG_HALF_ANGLE, 16'(pick(255)));
        cfg_write(REG_RETRACT_ANGLE, 16'(pick(180)));
        cfg_write(REG_SETTLE_MS, 16'(pick(65535)));
        cfg_write(REG_MIN_TICKS, 16'(pick(4095)));
        cfg_write(REG_MAX_TICKS, 16'(pick(4095)));
    endtask

    always @(posedge clk)
    begin : result_check
        servo_step_t got;
        servo_step_t want;
        if (rst_n && strobe)
        begin
            got = '{ok, channel, ticks, out_angle, settle_ms, last};
            if (pending_steps.size() == 0)
            begin
                $error("result beat with nothing expected: ok=%0d channel=%0d ticks=%0d",
                       ok, channel, ticks);
                errors++;
            end
            else
            begin
                want = pending_steps.pop_front();
                check_field("ok", want.ok, got.ok);
                check_field("channel", want.chan, got.chan);
                check_field("ticks", want.ticks, got.ticks);
                check_field("out_angle", want.ang, got.ang);
                check_field("settle_ms", want.settle, got.settle);
                check_field("last", want.last, got.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int                        phase;
        int                        n;
        int                        count;
        int                        sel;
        logic                      enable;
        logic                      c;
        logic [FEEDER_W-1:0]       f;
        logic signed [ANGLE_W-1:0] a;
        logic [LEN_W-1:0]          len;

        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = CMD_SET;
        feeder      = '0;
        angle       = '0;
        feed_length = '0;
        cfg_wr      = 1'b0;
        cfg_addr    = REG_GLOBAL_ENABLE;
        cfg_data    = '0;
        regs = '{RST_GLOBAL_ENABLE, RST_FEEDER_MASK, RST_FULL_ANGLE, RST_HALF_ANGLE,
                 RST_RETRACT_ANGLE, RST_SETTLE_MS, RST_MIN_TICKS, RST_MAX_TICKS};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_REG)
            begin
                await_idle();
                cfg_write(DIRECTED[i].idx, DIRECTED[i].value);
            end
            else
            begin
                send_command(DIRECTED[i].cmd, DIRECTED[i].feeder, DIRECTED[i].angle,
                             DIRECTED[i].len, DIRECTED[i].fixed, DIRECTED[i].want);
                pace();
            end
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            await_idle();
            enable  = (phase != 4);
            gaps_on = (phase % 3 != 1);
            randomise_regs(enable);
            count = enable ? 68 : 12;
            for (n = 0; n < count; n++)
            begin
                sel = $urandom_range(0, 99);
                f   = 4'($urandom_range(0, 15));
                a   = 10'($urandom_range(0, 1023));
                if (sel < 60)
                begin
                    c   = CMD_FEED;
                    len = 5'(2 * $urandom_range(1, 12));
                end
                else if (sel < 82)
                begin
                    c   = CMD_SET;
                    len = 5'($urandom_range(0, 31));
                end
                else
                begin
                    c   = CMD_FEED;
                    len = 5'($urandom_range(0, 31));
                end
                send_command(c, f, a, len, 1'b0, NO_STEP);
                if ($urandom_range(0, 24) == 0)
                    await_idle();
                else
                    pace();
            end
        end

        await_idle();
        repeat (30) @(posedge clk);
        if (errors == 0 && pending_steps.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> feeder_servo_step_sequencer_top.f
rtl/core/fss_pkg.sv
rtl/core/fss_datapath.sv
rtl/core/feeder_servo_step_sequencer_top.sv
tb/testbench.sv
